[rtl/hrrs_pkg.sv]
// package for the highest response ratio scheduler
// default sizes shared by the top level and its arithmetic unit; no dependencies
`timescale 1ns / 1ps
package hrrs_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TIME_BITS_DEF   = 16;
  localparam int unsigned ID_BITS_DEF     = 8;

endpackage

[rtl/hrrs_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module hrrs_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/hrrs_mul.sv]
// shared unsigned multiplier with registered product
// default width from hrrs_pkg
`timescale 1ns / 1ps
module hrrs_mul #(
  parameter int unsigned WIDTH = hrrs_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic [WIDTH-1:0]   a,
  input  logic [WIDTH-1:0]   b,
  output logic [2*WIDTH-1:0] p
);

  always_ff @(posedge clk) begin
    p <= (2*WIDTH)'(a) * (2*WIDTH)'(b);
  end

endmodule

[rtl/highest_response_ratio_scheduler_unit.sv]
// top level of the highest response ratio next scheduler
// uses hrrs_pkg, hrrs_ram (wait queue) and hrrs_mul (ratio compare multiplier)
`timescale 1ns / 1ps
// Non-preemptive highest-response-ratio-next scheduler. Each job word (id,
// arrival, process time, last flag) either starts at once, is queued, or is
// rejected when the queue is full; while the running finish time is before
// the new arrival, queued jobs with the highest wait/process ratio run first
// (exact cross-multiplied compare, earliest queued wins a tie). Every job that
// runs or is rejected gives one sched word with begin and finish minutes; the
// last word caused by a job word carries last_of_run, and a job word that only
// queues gives none. A last_job word drains the queue and clears the state.
// Timing: job_stall is high from acceptance until all words of that job are
// produced. Each pick of a queued job scans the n waiting entries one at a
// time through the single ram read port and the one shared multiplier (two
// products per entry), then issues the result, then moves each entry above
// the picked one down to close the gap in the queue.
// The wait queue needs no clearing after reset.
module highest_response_ratio_scheduler_unit #(
  parameter int unsigned QUEUE_DEPTH = hrrs_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TIME_BITS   = hrrs_pkg::TIME_BITS_DEF,
  parameter int unsigned ID_BITS     = hrrs_pkg::ID_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // job words in
  input  logic                 job_valid,
  output logic                 job_stall,
  input  logic [ID_BITS-1:0]   job_id,
  input  logic [TIME_BITS-1:0] arrive_minute,
  input  logic [TIME_BITS-1:0] process_minute,
  input  logic                 last_job,
  // schedule words out
  output logic                 sched_valid,
  input  logic                 sched_stall,
  output logic [ID_BITS-1:0]   sched_id,
  output logic [TIME_BITS-1:0] sched_arrive,
  output logic [TIME_BITS-1:0] sched_process,
  output logic [TIME_BITS-1:0] begin_minute,
  output logic [TIME_BITS-1:0] finish_minute,
  output logic                 rejected,
  output logic                 last_of_run
);
  import hrrs_pkg::*;

  localparam int unsigned IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRY_W = ID_BITS + 2 * TIME_BITS;
  localparam int unsigned PROD_W  = 2 * TIME_BITS;

  // sequencer states, one-hot
  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_CHECK = 12'b0000_0000_0010,
    ST_TAIL  = 12'b0000_0000_0100,
    ST_DRAIN = 12'b0000_0000_1000,
    ST_RD    = 12'b0000_0001_0000,
    ST_LD    = 12'b0000_0010_0000,
    ST_M1    = 12'b0000_0100_0000,
    ST_M2    = 12'b0000_1000_0000,
    ST_M3    = 12'b0001_0000_0000,
    ST_RUN   = 12'b0010_0000_0000,
    ST_SH_RD = 12'b0100_0000_0000,
    ST_SH_WR = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // scheduler state
  logic [CNT_W-1:0]     count;
  logic [TIME_BITS-1:0] finish;

  // current job word
  logic [ID_BITS-1:0]   item_id;
  logic [TIME_BITS-1:0] item_arr;
  logic [TIME_BITS-1:0] item_proc;
  logic                 item_last;
  logic                 started;
  logic                 drain_mode;

  // scan registers
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     best_idx;
  logic [ID_BITS-1:0]   best_id;
  logic [TIME_BITS-1:0] best_arr;
  logic [TIME_BITS-1:0] best_proc;
  logic [TIME_BITS-1:0] wb;
  logic [ID_BITS-1:0]   cand_id;
  logic [TIME_BITS-1:0] cand_arr;
  logic [TIME_BITS-1:0] cand_proc;
  logic [TIME_BITS-1:0] wc;
  logic [PROD_W-1:0]    prod_a;

  // ram and multiplier hookup
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [TIME_BITS-1:0] mul_a;
  logic [TIME_BITS-1:0] mul_b;
  logic [PROD_W-1:0]    mul_p;

  // fields of the word read from the queue (id, arrival, process)
  logic [ID_BITS-1:0]   rd_id;
  logic [TIME_BITS-1:0] rd_arr;
  logic [TIME_BITS-1:0] rd_proc;
  logic [TIME_BITS-1:0] rd_wait;

  logic                 out_free;
  logic [TIME_BITS:0]   sum_direct;
  logic [TIME_BITS:0]   sum_run;
  logic [TIME_BITS-1:0] fin_direct;
  logic [TIME_BITS-1:0] fin_run;
  logic                 queue_full;
  logic [CNT_W-1:0]     idx_inc;
  logic [CNT_W-1:0]     best_inc;

  assign rd_id   = ram_rdata[ENTRY_W-1 -: ID_BITS];
  assign rd_arr  = ram_rdata[2*TIME_BITS-1 -: TIME_BITS];
  assign rd_proc = ram_rdata[TIME_BITS-1:0];
  // waiting time so far, floored at zero for arrivals past the finish time
  assign rd_wait = (finish >= rd_arr) ? finish - rd_arr : '0;

  // a new sched word may be loaded when the output register is empty or leaving
  assign out_free = !sched_valid || !sched_stall;

  // finish times saturate at the all-ones minute
  assign sum_direct = {1'b0, item_arr} + {1'b0, item_proc};
  assign sum_run    = {1'b0, finish} + {1'b0, best_proc};
  assign fin_direct = sum_direct[TIME_BITS] ? '1 : sum_direct[TIME_BITS-1:0];
  assign fin_run    = sum_run[TIME_BITS] ? '1 : sum_run[TIME_BITS-1:0];

  assign queue_full = (count == CNT_W'(QUEUE_DEPTH));
  assign idx_inc    = CNT_W'(idx) + CNT_W'(1);
  assign best_inc   = CNT_W'(best_idx) + CNT_W'(1);

  assign job_stall = (state != ST_IDLE);

  // queue write: append in the tail step, close the gap while compacting
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = ram_rdata;
    ram_raddr = idx;
    unique case (state)
      ST_TAIL: begin
        ram_we    = !started && !queue_full;
        ram_waddr = count[IDX_W-1:0];
        ram_wdata = {item_id, item_arr, item_proc};
      end
      ST_SH_RD: begin
        ram_raddr = idx + IDX_W'(1);
      end
      ST_SH_WR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // multiplier operands: candidate wait times best process, then best wait
  // times candidate process
  always_comb begin
    if (state == ST_M2) begin
      mul_a = wb;
      mul_b = cand_proc;
    end else begin
      mul_a = wc;
      mul_b = best_proc;
    end
  end

  hrrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hrrs_mul #(
    .WIDTH (TIME_BITS)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      finish      <= '0;
      sched_valid <= 1'b0;
      started     <= 1'b0;
      drain_mode  <= 1'b0;
    end else begin
      if (!sched_stall) begin
        sched_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            item_id   <= job_id;
            item_arr  <= arrive_minute;
            item_proc <= process_minute;
            item_last <= last_job;
            started   <= 1'b0;
            state     <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (finish < item_arr) begin
            if (count == '0) begin
              // queue empty: the new job starts at its arrival
              if (out_free) begin
                sched_valid   <= 1'b1;
                sched_id      <= item_id;
                sched_arrive  <= item_arr;
                sched_process <= item_proc;
                begin_minute  <= item_arr;
                finish_minute <= fin_direct;
                rejected      <= 1'b0;
                last_of_run   <= 1'b1;
                finish        <= fin_direct;
                started       <= 1'b1;
                state         <= ST_TAIL;
              end
            end else begin
              drain_mode <= 1'b0;
              idx        <= '0;
              state      <= ST_RD;
            end
          end else begin
            state <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          if (started) begin
            state <= ST_DRAIN;
          end else if (!queue_full) begin
            count <= count + CNT_W'(1);
            state <= ST_DRAIN;
          end else if (out_free) begin
            // queue full: job is dropped
            sched_valid   <= 1'b1;
            sched_id      <= item_id;
            sched_arrive  <= item_arr;
            sched_process <= item_proc;
            begin_minute  <= '0;
            finish_minute <= '0;
            rejected      <= 1'b1;
            last_of_run   <= !item_last;
            state         <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!item_last) begin
            state <= ST_IDLE;
          end else if (count != '0) begin
            drain_mode <= 1'b1;
            idx        <= '0;
            state      <= ST_RD;
          end else begin
            finish <= '0;
            state  <= ST_IDLE;
          end
        end
        ST_RD: begin
          state <= ST_LD;
        end
        ST_LD: begin
          if (idx == '0) begin
            // first entry seeds the best pick
            best_idx  <= '0;
            best_id   <= rd_id;
            best_arr  <= rd_arr;
            best_proc <= rd_proc;
            wb        <= rd_wait;
            if (count == CNT_W'(1)) begin
              state <= ST_RUN;
            end else begin
              idx   <= IDX_W'(1);
              state <= ST_RD;
            end
          end else begin
            cand_id   <= rd_id;
            cand_arr  <= rd_arr;
            cand_proc <= rd_proc;
            wc        <= rd_wait;
            state     <= ST_M1;
          end
        end
        ST_M1: begin
          state <= ST_M2;
        end
        ST_M2: begin
          prod_a <= mul_p;
          state  <= ST_M3;
        end
        ST_M3: begin
          // strictly greater ratio replaces, so ties keep the earlier entry
          if (prod_a > mul_p) begin
            best_idx  <= idx;
            best_id   <= cand_id;
            best_arr  <= cand_arr;
            best_proc <= cand_proc;
            wb        <= wc;
          end
          if (idx_inc == count) begin
            state <= ST_RUN;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= ST_RD;
          end
        end
        ST_RUN: begin
          if (out_free) begin
            sched_valid   <= 1'b1;
            sched_id      <= best_id;
            sched_arrive  <= best_arr;
            sched_process <= best_proc;
            begin_minute  <= finish;
            finish_minute <= fin_run;
            rejected      <= 1'b0;
            if (drain_mode) begin
              last_of_run <= (count == CNT_W'(1));
            end else begin
              // more words follow if the loop goes on or a drain comes
              last_of_run <= !((fin_run < item_arr) || item_last);
            end
            finish <= fin_run;
            count  <= count - CNT_W'(1);
            if (best_inc < count) begin
              idx   <= best_idx;
              state <= ST_SH_RD;
            end else begin
              state <= drain_mode ? ST_DRAIN : ST_CHECK;
            end
          end
        end
        ST_SH_RD: begin
          state <= ST_SH_WR;
        end
        ST_SH_WR: begin
          // count already holds the reduced fill
          if (idx_inc < count) begin
            idx   <= idx + IDX_W'(1);
            state <= ST_SH_RD;
          end else begin
            state <= drain_mode ? ST_DRAIN : ST_CHECK;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
